### src/spe_pkg.sv
// ----------------------------------------------------------------------------
// spe_pkg
// Types, codes and protocol constants shared by the servo packet engine.
// ----------------------------------------------------------------------------
`default_nettype none

package spe_pkg;

	typedef enum logic [2:0] {
		ACT_SET   = 3'd0,
		ACT_READ  = 3'd1,
		ACT_RX    = 3'd2,
		ACT_END   = 3'd3,
		ACT_QUERY = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		KIND_TX     = 2'd0,
		KIND_STATUS = 2'd1,
		KIND_QUERY  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_SHORT    = 3'd1,
		ST_HEADER   = 3'd2,
		ST_LENGTH   = 3'd3,
		ST_CHECKSUM = 3'd4,
		ST_ACK_BAD  = 3'd5,
		ST_UNKNOWN  = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		EXP_NONE = 2'd0,
		EXP_ACK  = 2'd1,
		EXP_POS  = 2'd2
	} expect_t;

	typedef enum logic [1:0] {
		REG_CAM_MAX = 2'd0,
		REG_CAM_MIN = 2'd1,
		REG_ARM_MAX = 2'd2,
		REG_ARM_MIN = 2'd3
	} reg_idx_t;

	localparam logic [7:0] BYTE_HDR      = 8'hFF;
	localparam logic [7:0] WR_LEN        = 8'h09;
	localparam logic [7:0] INS_WRITE     = 8'h03;
	localparam logic [7:0] ADDR_GOAL     = 8'h2A;
	localparam logic [7:0] RD_LEN        = 8'h04;
	localparam logic [7:0] INS_READ      = 8'h02;
	localparam logic [7:0] ADDR_POS      = 8'h38;
	localparam logic [7:0] RD_COUNT      = 8'h02;
	localparam logic [7:0] ACK_LEN       = 8'h02;
	localparam logic [7:0] ACK_ERR       = 8'h00;
	localparam logic [7:0] POS_REPLY_LEN = 8'h04;

	localparam logic [3:0] WR_FRAME_LEN  = 4'd13;
	localparam logic [3:0] RD_FRAME_LEN  = 4'd8;
	localparam logic [3:0] ACK_RX_LEN    = 4'd6;
	localparam logic [3:0] POS_RX_LEN    = 4'd8;

	localparam logic [15:0] CAM_MAX_RST = 16'd2700;
	localparam logic [15:0] CAM_MIN_RST = 16'd1500;
	localparam logic [15:0] ARM_MAX_RST = 16'd3118;
	localparam logic [15:0] ARM_MIN_RST = 16'd2047;

	typedef struct packed {
		action_t     action;
		logic [7:0]  servo_id;
		logic [15:0] target_pos;
		logic [15:0] move_time;
		logic [15:0] move_speed;
		logic [7:0]  rx_byte;
	} item_t;

	typedef struct packed {
		logic [15:0] cam_max;
		logic [15:0] cam_min;
		logic [15:0] arm_max;
		logic [15:0] arm_min;
	} limits_t;

	// One command's worth of results handed to the output buffer.
	typedef struct packed {
		logic             load;
		kind_t            kind;
		logic [3:0]       len;
		logic [12:0][7:0] frame;
		status_t          status;
		logic [7:0]       id;
		logic [15:0]      pos;
	} job_t;

endpackage

`default_nettype wire

### src/spe_core.sv
// ----------------------------------------------------------------------------
// spe_core
// Command execution: frame build, position clamp, response checking and
// the stored position table.
// ----------------------------------------------------------------------------
`default_nettype none

module spe_core #(
	parameter int SERVO_COUNT = 3
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           rd_en,
	input  wire logic [7:0]     rd_id,
	input  wire logic           exec,
	input  wire spe_pkg::item_t item,
	input  wire spe_pkg::limits_t lim,
	output spe_pkg::job_t       job
);

	localparam int AW = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;
	localparam logic [7:0] CNT8 = 8'(SERVO_COUNT);

	spe_pkg::expect_t exp_q, exp_d;
	logic [7:0]  exp_id_q, exp_id_d;
	logic [3:0]  rx_cnt_q, rx_cnt_d;
	logic        rpt_q, rpt_d;
	logic [7:0]  rx_q [8];

	logic [15:0] mem [SERVO_COUNT];
	logic [SERVO_COUNT-1:0] vld_q;
	logic [15:0] mem_rd_q;
	logic        vld_rd_q;
	logic        fwd_q;
	logic [15:0] fwd_data_q;

	logic        wr_en;
	logic [7:0]  rid;
	logic [7:0]  wa_full, ra_full;
	logic [AW-1:0] wa, ra;
	logic [15:0] wr_data;
	logic [15:0] stored_pos;

	logic        id_ok, rid_ok, cam;
	logic signed [15:0] pos_s, hi_s, lo_s, clamp_s;
	logic [15:0] clamp;
	logic [7:0]  wr_sum, rd_sum, ack_sum, pos_sum;
	logic        active, rx_wr, rx_final, ack_match;
	logic [3:0]  cnt_n;
	logic [7:0]  v [8];

	assign id_ok  = (item.servo_id != 8'd0) && (item.servo_id <= CNT8);
	assign cam    = (item.servo_id == 8'd1);
	assign pos_s  = $signed(item.target_pos);
	assign hi_s   = $signed(cam ? lim.cam_max : lim.arm_max);
	assign lo_s   = $signed(cam ? lim.cam_min : lim.arm_min);
	// upper bound is checked first: with crossed limits a value above it takes the upper bound, any other the lower
	assign clamp_s = (pos_s > hi_s) ? hi_s : ((pos_s < lo_s) ? lo_s : pos_s);
	assign clamp   = clamp_s;

	assign wr_sum = item.servo_id + spe_pkg::WR_LEN + spe_pkg::INS_WRITE
		+ spe_pkg::ADDR_GOAL + clamp[7:0] + clamp[15:8]
		+ item.move_time[7:0] + item.move_time[15:8]
		+ item.move_speed[7:0] + item.move_speed[15:8];
	assign rd_sum = item.servo_id + spe_pkg::RD_LEN + spe_pkg::INS_READ
		+ spe_pkg::ADDR_POS + spe_pkg::RD_COUNT;

	// receive path: the byte arriving now is merged into the view
	assign active = (exp_q != spe_pkg::EXP_NONE) && !rpt_q;
	assign rx_wr  = exec && (item.action == spe_pkg::ACT_RX) && active && !rx_cnt_q[3];
	assign cnt_n  = rx_cnt_q + 4'd1;
	assign rx_final = active && (((exp_q == spe_pkg::EXP_ACK) && (cnt_n == spe_pkg::ACK_RX_LEN))
		|| ((exp_q == spe_pkg::EXP_POS) && (cnt_n == spe_pkg::POS_RX_LEN)));

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			v[i] = (rx_wr && (rx_cnt_q[2:0] == 3'(i))) ? item.rx_byte : rx_q[i];
		end
	end

	assign ack_sum   = ~(exp_id_q + spe_pkg::ACK_LEN);
	assign ack_match = (v[0] == spe_pkg::BYTE_HDR) && (v[1] == spe_pkg::BYTE_HDR)
		&& (v[2] == exp_id_q) && (v[3] == spe_pkg::ACK_LEN)
		&& (v[4] == spe_pkg::ACK_ERR) && (v[5] == ack_sum);
	assign pos_sum = ~(v[2] + v[3] + v[4] + v[5] + v[6]);
	assign rid     = v[2];
	assign rid_ok  = (rid != 8'd0) && (rid <= CNT8);
	assign wr_data = {v[6], v[5]};

	// position table: read issued when the item is taken in, write at execution
	assign wa_full = rid - 8'd1;
	assign ra_full = rd_id - 8'd1;
	assign wa = wa_full[AW-1:0];
	assign ra = ra_full[AW-1:0];
	assign stored_pos = fwd_q ? fwd_data_q : (vld_rd_q ? mem_rd_q : 16'd0);

	always_comb begin
		job     = '0;
		exp_d   = exp_q;
		exp_id_d = exp_id_q;
		rx_cnt_d = rx_cnt_q;
		rpt_d   = rpt_q;
		wr_en   = 1'b0;
		case (item.action)
			spe_pkg::ACT_SET: begin
				if (id_ok) begin
					job.load  = 1'b1;
					job.kind  = spe_pkg::KIND_TX;
					job.len   = spe_pkg::WR_FRAME_LEN;
					job.frame = {~wr_sum, item.move_speed[15:8], item.move_speed[7:0],
						item.move_time[15:8], item.move_time[7:0], clamp[15:8], clamp[7:0],
						spe_pkg::ADDR_GOAL, spe_pkg::INS_WRITE, spe_pkg::WR_LEN,
						item.servo_id, spe_pkg::BYTE_HDR, spe_pkg::BYTE_HDR};
					exp_d    = spe_pkg::EXP_ACK;
					exp_id_d = item.servo_id;
					rx_cnt_d = 4'd0;
					rpt_d    = 1'b0;
				end
			end
			spe_pkg::ACT_READ: begin
				if (id_ok) begin
					job.load  = 1'b1;
					job.kind  = spe_pkg::KIND_TX;
					job.len   = spe_pkg::RD_FRAME_LEN;
					job.frame = {40'd0, ~rd_sum, spe_pkg::RD_COUNT, spe_pkg::ADDR_POS,
						spe_pkg::INS_READ, spe_pkg::RD_LEN, item.servo_id,
						spe_pkg::BYTE_HDR, spe_pkg::BYTE_HDR};
					exp_d    = spe_pkg::EXP_POS;
					exp_id_d = item.servo_id;
					rx_cnt_d = 4'd0;
					rpt_d    = 1'b0;
				end
			end
			spe_pkg::ACT_RX: begin
				if (active) begin
					rx_cnt_d = cnt_n;
					if (rx_final) begin
						rpt_d    = 1'b1;
						job.load = 1'b1;
						job.kind = spe_pkg::KIND_STATUS;
						job.len  = 4'd1;
						if (exp_q == spe_pkg::EXP_ACK) begin
							job.id     = exp_id_q;
							job.status = ack_match ? spe_pkg::ST_OK : spe_pkg::ST_ACK_BAD;
						end else begin
							job.id = rid;
							if (v[0] != spe_pkg::BYTE_HDR || v[1] != spe_pkg::BYTE_HDR) begin
								job.status = spe_pkg::ST_HEADER;
							end else if (v[3] != spe_pkg::POS_REPLY_LEN) begin
								job.status = spe_pkg::ST_LENGTH;
							end else if (v[7] != pos_sum) begin
								job.status = spe_pkg::ST_CHECKSUM;
							end else if (!rid_ok) begin
								job.status = spe_pkg::ST_UNKNOWN;
							end else begin
								job.status = spe_pkg::ST_OK;
								job.pos    = wr_data;
								wr_en      = 1'b1;
							end
						end
					end
				end
			end
			spe_pkg::ACT_END: begin
				if (active) begin
					job.load   = 1'b1;
					job.kind   = spe_pkg::KIND_STATUS;
					job.len    = 4'd1;
					job.status = spe_pkg::ST_SHORT;
					job.id     = exp_id_q;
				end
				exp_d    = spe_pkg::EXP_NONE;
				rx_cnt_d = 4'd0;
				rpt_d    = 1'b0;
			end
			spe_pkg::ACT_QUERY: begin
				job.load   = 1'b1;
				job.kind   = spe_pkg::KIND_QUERY;
				job.len    = 4'd1;
				job.id     = item.servo_id;
				job.status = id_ok ? spe_pkg::ST_OK : spe_pkg::ST_UNKNOWN;
				job.pos    = id_ok ? stored_pos : 16'd0;
			end
			default: begin
			end
		endcase
		if (!exec) begin
			job.load = 1'b0;
			wr_en    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q    <= spe_pkg::EXP_NONE;
			exp_id_q <= 8'd0;
			rx_cnt_q <= 4'd0;
			rpt_q    <= 1'b0;
			vld_q    <= '0;
		end else begin
			if (exec) begin
				exp_q    <= exp_d;
				exp_id_q <= exp_id_d;
				rx_cnt_q <= rx_cnt_d;
				rpt_q    <= rpt_d;
			end
			if (wr_en) begin
				vld_q[wa] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx_wr) begin
			rx_q[rx_cnt_q[2:0]] <= item.rx_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wa] <= wr_data;
		end
		if (rd_en) begin
			mem_rd_q   <= mem[ra];
			vld_rd_q   <= vld_q[ra];
			fwd_q      <= wr_en && (wa == ra);
			fwd_data_q <= wr_data;
		end
	end

endmodule

`default_nettype wire

### src/spe_out.sv
// ----------------------------------------------------------------------------
// spe_out
// Output buffer: holds one command's results and shifts them out one
// transfer at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module spe_out (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire spe_pkg::job_t job,
	output logic               free,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output logic [39:0]        m_tdata,   // tx_byte, status, reply_id, reply_pos
	output logic [1:0]         m_tuser,   // kind
	output logic               m_tlast
);

	logic             valid_q;
	spe_pkg::kind_t   kind_q;
	logic [3:0]       rem_q;
	logic [12:0][7:0] frame_q;
	spe_pkg::status_t status_q;
	logic [7:0]       id_q;
	logic [15:0]      pos_q;
	logic             xfer, at_last;

	assign at_last = (rem_q == 4'd1);
	assign xfer    = valid_q && m_tready;
	assign free    = !valid_q || (m_tready && at_last);

	assign m_tvalid = valid_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = at_last;
	assign m_tdata  = {5'd0, pos_q, id_q, status_q, frame_q[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rem_q   <= 4'd0;
		end else if (job.load) begin
			valid_q <= 1'b1;
			rem_q   <= job.len;
		end else if (xfer) begin
			valid_q <= !at_last;
			rem_q   <= rem_q - 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (job.load) begin
			kind_q   <= job.kind;
			frame_q  <= job.frame;
			status_q <= job.status;
			id_q     <= job.id;
			pos_q    <= job.pos;
		end else if (xfer) begin
			frame_q <= {8'd0, frame_q[12:1]};
		end
	end

endmodule

`default_nettype wire

### src/servo_packet_engine.sv
// ----------------------------------------------------------------------------
// servo_packet_engine
// Serial servo packet engine: builds write and read frames, checks responses
// and keeps the last position read back from each servo.
// ----------------------------------------------------------------------------
// A command is registered at the input and its results in the output buffer.
// Throughput: one output transfer a cycle while m_tready is high; a set
// command gives 13 transfers, a read request 8, every other command at most 1.
// The next command is taken in while the current results drain.
// Reset (arst_n low) clears the windows and the stored positions and
// returns the limits to their defaults.
`default_nettype none

module servo_packet_engine #(
	parameter int SERVO_COUNT = 3
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // servo_id, target_pos, move_time, move_speed, rx_byte
	input  wire logic [2:0]  s_tuser,   // action
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // tx_byte, status, reply_id, reply_pos
	output logic [1:0]       m_tuser,   // kind
	output logic             m_tlast,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_wdata
);

	logic            item_valid_s1;
	spe_pkg::item_t  item_s1;
	spe_pkg::limits_t lim_q;
	spe_pkg::job_t   job;
	logic            out_free, exec, take;

	assign exec     = item_valid_s1 && out_free;
	assign s_tready = !item_valid_s1 || exec;
	assign take     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			item_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.action     <= spe_pkg::action_t'(s_tuser);
			item_s1.servo_id   <= s_tdata[7:0];
			item_s1.target_pos <= s_tdata[23:8];
			item_s1.move_time  <= s_tdata[39:24];
			item_s1.move_speed <= s_tdata[55:40];
			item_s1.rx_byte    <= s_tdata[63:56];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q.cam_max <= spe_pkg::CAM_MAX_RST;
			lim_q.cam_min <= spe_pkg::CAM_MIN_RST;
			lim_q.arm_max <= spe_pkg::ARM_MAX_RST;
			lim_q.arm_min <= spe_pkg::ARM_MIN_RST;
		end else if (cfg_we) begin
			case (spe_pkg::reg_idx_t'(cfg_index))
				spe_pkg::REG_CAM_MAX: lim_q.cam_max <= cfg_wdata;
				spe_pkg::REG_CAM_MIN: lim_q.cam_min <= cfg_wdata;
				spe_pkg::REG_ARM_MAX: lim_q.arm_max <= cfg_wdata;
				spe_pkg::REG_ARM_MIN: lim_q.arm_min <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	spe_core #(
		.SERVO_COUNT(SERVO_COUNT)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (take),
		.rd_id  (s_tdata[7:0]),
		.exec   (exec),
		.item   (item_s1),
		.lim    (lim_q),
		.job    (job)
	);

	spe_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.job      (job),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

### bench/servo_frame_tracker.sv
// ----------------------------------------------------------------------------
// servo_frame_tracker
// Follows every transfer on the command and result streams of the servo
// packet engine. It keeps its own copy of the limits, the receive window and
// the stored positions, works out the frame bytes and statuses that each
// command causes, and compares them in order with what the engine sends.
// ----------------------------------------------------------------------------
module servo_frame_tracker #(
	parameter int SERVO_COUNT = 3
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [63:0] s_tdata,   // servo_id, target_pos, move_time, move_speed, rx_byte
	input  wire logic [2:0]  s_tuser,   // action
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [39:0] m_tdata,   // tx_byte, status, reply_id, reply_pos
	input  wire logic [1:0]  m_tuser,   // kind
	input  wire logic        m_tlast,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_wdata,
	output int               mismatch_count,
	output int               results_due
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [7:0] CAM_SERVO = 8'd1;

	typedef struct packed {
		spe_pkg::kind_t   kind;
		logic [7:0]       tx;
		logic             last;
		spe_pkg::status_t status;
		logic [7:0]       id;
		logic [15:0]      pos;
	} result_t;

	result_t          due_results [$];
	logic [15:0]      limits [4];
	logic [15:0]      stored_pos [1:SERVO_COUNT];
	spe_pkg::expect_t window_kind;
	logic [7:0]       window_id;
	int               rx_seen;
	logic [7:0]       rx_buf [8];
	bit               window_done;

	initial begin
		mismatch_count = 0;
		results_due = 0;
	end

	function automatic bit known_id(logic [7:0] id);
		return id >= 1 && id <= SERVO_COUNT;
	endfunction

	task automatic report_mismatch(string msg);
		$display("%0t ns: servo engine mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic queue_result(spe_pkg::kind_t k, logic [7:0] tx, logic lst,
			spe_pkg::status_t st, logic [7:0] id, logic [15:0] pos);
		result_t r;
		r.kind = k;
		r.tx = tx;
		r.last = lst;
		r.status = st;
		r.id = id;
		r.pos = pos;
		due_results.push_back(r);
	endtask

	// header, body, then the inverted sum of the body
	task automatic queue_frame(logic [9:0][7:0] body, int n);
		logic [7:0] sum;
		sum = '0;
		queue_result(spe_pkg::KIND_TX, spe_pkg::BYTE_HDR, 1'b0, spe_pkg::ST_OK, '0, '0);
		queue_result(spe_pkg::KIND_TX, spe_pkg::BYTE_HDR, 1'b0, spe_pkg::ST_OK, '0, '0);
		for (int i = 0; i < n; i++) begin
			sum += body[i];
			queue_result(spe_pkg::KIND_TX, body[i], 1'b0, spe_pkg::ST_OK, '0, '0);
		end
		queue_result(spe_pkg::KIND_TX, ~sum, 1'b1, spe_pkg::ST_OK, '0, '0);
	endtask

	task automatic open_window(spe_pkg::expect_t k, logic [7:0] id);
		window_kind = k;
		window_id = id;
		rx_seen = 0;
		window_done = 0;
	endtask

	task automatic model_command(logic [2:0] act, logic [7:0] id, logic [15:0] want,
			logic [15:0] tim, logic [15:0] spd, logic [7:0] rxb);
		logic signed [15:0] hi, lo, pos;
		logic [9:0][7:0]    body;
		logic [7:0]         sum, rid;
		int                 need;
		spe_pkg::status_t   st;
		logic [15:0]        val;
		body = '0;
		case (act)
			spe_pkg::ACT_SET: begin
				if (known_id(id)) begin
					hi = (id == CAM_SERVO) ? limits[spe_pkg::REG_CAM_MAX]
						: limits[spe_pkg::REG_ARM_MAX];
					lo = (id == CAM_SERVO) ? limits[spe_pkg::REG_CAM_MIN]
						: limits[spe_pkg::REG_ARM_MIN];
					pos = want;
					// upper bound is checked first: with crossed limits a value above it takes the upper bound, any other the lower
					if (pos > hi)
						pos = hi;
					else if (pos < lo)
						pos = lo;
					body = {spd[15:8], spd[7:0], tim[15:8], tim[7:0], pos[15:8], pos[7:0],
						spe_pkg::ADDR_GOAL, spe_pkg::INS_WRITE, spe_pkg::WR_LEN, id};
					open_window(spe_pkg::EXP_ACK, id);
					queue_frame(body, 10);
				end
			end
			spe_pkg::ACT_READ: begin
				if (known_id(id)) begin
					body[4:0] = {spe_pkg::RD_COUNT, spe_pkg::ADDR_POS, spe_pkg::INS_READ,
						spe_pkg::RD_LEN, id};
					open_window(spe_pkg::EXP_POS, id);
					queue_frame(body, 5);
				end
			end
			spe_pkg::ACT_RX: begin
				if (window_kind != spe_pkg::EXP_NONE && !window_done) begin
					need = (window_kind == spe_pkg::EXP_ACK) ? int'(spe_pkg::ACK_RX_LEN)
						: int'(spe_pkg::POS_RX_LEN);
					rx_buf[rx_seen] = rxb;
					rx_seen++;
					if (rx_seen == need) begin
						window_done = 1;
						if (window_kind == spe_pkg::EXP_ACK) begin
							sum = ~(window_id + spe_pkg::ACK_LEN);
							if (rx_buf[0] == spe_pkg::BYTE_HDR && rx_buf[1] == spe_pkg::BYTE_HDR &&
									rx_buf[2] == window_id && rx_buf[3] == spe_pkg::ACK_LEN &&
									rx_buf[4] == spe_pkg::ACK_ERR && rx_buf[5] == sum)
								st = spe_pkg::ST_OK;
							else
								st = spe_pkg::ST_ACK_BAD;
							queue_result(spe_pkg::KIND_STATUS, '0, 1'b1, st, window_id, '0);
						end else begin
							rid = rx_buf[2];
							sum = rx_buf[2] + rx_buf[3] + rx_buf[4] + rx_buf[5] + rx_buf[6];
							sum = ~sum;
							val = '0;
							if (rx_buf[0] != spe_pkg::BYTE_HDR || rx_buf[1] != spe_pkg::BYTE_HDR)
								st = spe_pkg::ST_HEADER;
							else if (rx_buf[3] != spe_pkg::POS_REPLY_LEN)
								st = spe_pkg::ST_LENGTH;
							else if (rx_buf[7] != sum)
								st = spe_pkg::ST_CHECKSUM;
							else if (!known_id(rid))
								st = spe_pkg::ST_UNKNOWN;
							else begin
								st = spe_pkg::ST_OK;
								val = {rx_buf[6], rx_buf[5]};
								stored_pos[rid] = val;
							end
							queue_result(spe_pkg::KIND_STATUS, '0, 1'b1, st, rid, val);
						end
					end
				end
			end
			spe_pkg::ACT_END: begin
				if (window_kind != spe_pkg::EXP_NONE && !window_done)
					queue_result(spe_pkg::KIND_STATUS, '0, 1'b1, spe_pkg::ST_SHORT,
						window_id, '0);
				window_kind = spe_pkg::EXP_NONE;
				rx_seen = 0;
				window_done = 0;
			end
			spe_pkg::ACT_QUERY: begin
				if (known_id(id))
					queue_result(spe_pkg::KIND_QUERY, '0, 1'b1, spe_pkg::ST_OK, id,
						stored_pos[id]);
				else
					queue_result(spe_pkg::KIND_QUERY, '0, 1'b1, spe_pkg::ST_UNKNOWN, id, '0);
			end
			default: ;
		endcase
	endtask

	task automatic check_result();
		result_t want;
		if (due_results.size() == 0) begin
			report_mismatch($sformatf("result kind %0d with nothing due", m_tuser));
			return;
		end
		want = due_results.pop_front();
		if (m_tuser != want.kind)
			report_mismatch($sformatf("kind %0d, expected %0d", m_tuser, want.kind));
		if (m_tdata[7:0] != want.tx)
			report_mismatch($sformatf("tx_byte %h, expected %h", m_tdata[7:0], want.tx));
		if (m_tlast != want.last)
			report_mismatch($sformatf("last %0d, expected %0d", m_tlast, want.last));
		if (m_tdata[10:8] != want.status)
			report_mismatch($sformatf("status %0d, expected %0d", m_tdata[10:8], want.status));
		if (m_tdata[18:11] != want.id)
			report_mismatch($sformatf("reply_id %0d, expected %0d", m_tdata[18:11], want.id));
		if (m_tdata[34:19] != want.pos)
			report_mismatch($sformatf("reply_pos %h, expected %h", m_tdata[34:19], want.pos));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			due_results.delete();
			limits[spe_pkg::REG_CAM_MAX] = spe_pkg::CAM_MAX_RST;
			limits[spe_pkg::REG_CAM_MIN] = spe_pkg::CAM_MIN_RST;
			limits[spe_pkg::REG_ARM_MAX] = spe_pkg::ARM_MAX_RST;
			limits[spe_pkg::REG_ARM_MIN] = spe_pkg::ARM_MIN_RST;
			for (int i = 1; i <= SERVO_COUNT; i++)
				stored_pos[i] = '0;
			for (int i = 0; i < 8; i++)
				rx_buf[i] = '0;
			open_window(spe_pkg::EXP_NONE, '0);
			results_due = 0;
		end else begin
			// results first: nothing leaves the engine in the cycle it is taken in
			if (m_tvalid && m_tready)
				check_result();
			if (cfg_we)
				limits[cfg_index] = cfg_wdata;
			if (s_tvalid && s_tready)
				model_command(s_tuser, s_tdata[7:0], s_tdata[23:8], s_tdata[39:24],
					s_tdata[55:40], s_tdata[63:56]);
			results_due = due_results.size();
		end
	end

endmodule

### bench/tb_servo_packet_engine.sv
// ----------------------------------------------------------------------------
// tb_servo_packet_engine
// Drives set, read, receive, window-end and query commands into the servo
// packet engine under several limit settings, with random gaps on the
// command side and random back-pressure on the result side. The checker
// beside the engine predicts and compares every result transfer.
// ----------------------------------------------------------------------------
module tb_servo_packet_engine;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SERVO_COUNT = 3;
	localparam logic [7:0] CAM_SERVO = 8'd1;
	localparam int SETTLE_CYCLES = 8;
	localparam int STALL_LIMIT = 4000;

	typedef enum int {
		SHAPE_GOOD,
		SHAPE_FLIP,
		SHAPE_HEADER,
		SHAPE_LENGTH,
		SHAPE_CHECKSUM,
		SHAPE_SHORT,
		SHAPE_EXTRA
	} reply_shape_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;    // servo_id, target_pos, move_time, move_speed, rx_byte
	logic [2:0]  s_tuser;    // action
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;    // tx_byte, status, reply_id, reply_pos
	logic [1:0]  m_tuser;    // kind
	logic        m_tlast;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_wdata;
	int          mismatch_count;
	int          results_due;

	bit                 calm;
	int                 items_sent;
	logic signed [15:0] cam_hi, cam_lo, arm_hi, arm_lo;

	servo_packet_engine #(.SERVO_COUNT(SERVO_COUNT)) uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	servo_frame_tracker #(.SERVO_COUNT(SERVO_COUNT)) tracker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.mismatch_count(mismatch_count), .results_due(results_due)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// result side back-pressure
	initial begin
		int stall;
		m_tready = 1'b0;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall > 0 && !calm) begin
				m_tready <= 1'b0;
				stall--;
			end else begin
				m_tready <= 1'b1;
				stall = 0;
				if (!calm && $urandom_range(0, 11) == 0)
					stall = $urandom_range(1, 14);
			end
		end
	end

	// ends the run when nothing moves for too long
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				quiet = 0;
			else
				quiet++;
		end
		$display("servo_packet_engine verification failed");
		$finish;
	end

	task automatic send_item(logic [2:0] act, logic [7:0] id, logic [15:0] pos,
			logic [15:0] tim, logic [15:0] spd, logic [7:0] rxb);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(0, 7) == 0)
			gap = $urandom_range(1, 14);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {rxb, spd, tim, pos, id};
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	task automatic send_cmd(logic [2:0] act, logic [7:0] id, logic [15:0] pos,
			logic [15:0] tim, logic [15:0] spd);
		send_item(act, id, pos, tim, spd, 8'($urandom));
	endtask

	task automatic send_rx(logic [7:0] b);
		send_item(spe_pkg::ACT_RX, 8'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), b);
	endtask

	task automatic close_window();
		send_cmd(spe_pkg::ACT_END, 8'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom));
	endtask

	task automatic send_ack(logic [7:0] id, reply_shape_t shape);
		logic [7:0][7:0] fb;
		int cut;
		fb = '0;
		fb[0] = spe_pkg::BYTE_HDR;
		fb[1] = spe_pkg::BYTE_HDR;
		fb[2] = id;
		fb[3] = spe_pkg::ACK_LEN;
		fb[4] = spe_pkg::ACK_ERR;
		fb[5] = ~(id + spe_pkg::ACK_LEN);
		cut = int'(spe_pkg::ACK_RX_LEN);
		if (shape == SHAPE_FLIP)
			fb[3'($urandom_range(0, int'(spe_pkg::ACK_RX_LEN) - 1))] ^=
				8'($urandom_range(1, 255));
		if (shape == SHAPE_SHORT)
			cut = $urandom_range(0, int'(spe_pkg::ACK_RX_LEN) - 1);
		for (int i = 0; i < cut; i++)
			send_rx(fb[i]);
		if (shape == SHAPE_EXTRA)
			send_rx(8'($urandom));
		if (shape == SHAPE_SHORT || shape == SHAPE_EXTRA)
			close_window();
	endtask

	task automatic send_position_reply(logic [7:0] rid, reply_shape_t shape);
		logic [7:0][7:0] fb;
		logic [7:0]      sum;
		int              cut;
		fb[0] = spe_pkg::BYTE_HDR;
		fb[1] = spe_pkg::BYTE_HDR;
		fb[2] = rid;
		fb[3] = spe_pkg::POS_REPLY_LEN;
		fb[4] = 8'($urandom);
		fb[5] = 8'($urandom);
		fb[6] = 8'($urandom);
		if (shape == SHAPE_LENGTH || (shape == SHAPE_HEADER && $urandom_range(0, 1)))
			fb[3] ^= 8'($urandom_range(1, 255));
		sum = fb[2] + fb[3] + fb[4] + fb[5] + fb[6];
		fb[7] = ~sum;
		if (shape == SHAPE_HEADER)
			fb[3'($urandom_range(0, 1))] ^= 8'($urandom_range(1, 255));
		if (shape == SHAPE_CHECKSUM)
			fb[7] ^= 8'($urandom_range(1, 255));
		cut = (shape == SHAPE_SHORT) ? int'($urandom_range(0, int'(spe_pkg::POS_RX_LEN) - 1))
			: int'(spe_pkg::POS_RX_LEN);
		for (int i = 0; i < cut; i++)
			send_rx(fb[i]);
		if (shape == SHAPE_EXTRA)
			send_rx(8'($urandom));
		if (shape == SHAPE_SHORT || shape == SHAPE_EXTRA)
			close_window();
	endtask

	// lets every due result through, then any command still inside the engine
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (results_due != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_limit(spe_pkg::reg_idx_t idx, logic [15:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_limits(logic [15:0] cmax, logic [15:0] cmin,
			logic [15:0] amax, logic [15:0] amin);
		write_limit(spe_pkg::REG_CAM_MAX, cmax);
		write_limit(spe_pkg::REG_CAM_MIN, cmin);
		write_limit(spe_pkg::REG_ARM_MAX, amax);
		write_limit(spe_pkg::REG_ARM_MIN, amin);
		cam_hi = cmax;
		cam_lo = cmin;
		arm_hi = amax;
		arm_lo = amin;
	endtask

	function automatic logic [7:0] pick_servo();
		if ($urandom_range(0, 99) < 85)
			return 8'($urandom_range(1, SERVO_COUNT));
		return 8'($urandom_range(0, 255));
	endfunction

	// half the time near the clamp edges, since that is where the frames differ
	function automatic logic [15:0] pick_target(logic [7:0] id);
		logic signed [15:0] hi, lo;
		int span;
		hi = (id == CAM_SERVO) ? cam_hi : arm_hi;
		lo = (id == CAM_SERVO) ? cam_lo : arm_lo;
		case ($urandom_range(0, 3))
			0: return 16'($urandom);
			1: return 16'(hi + $urandom_range(0, 4) - 2);
			2: return 16'(lo + $urandom_range(0, 4) - 2);
			default: begin
				if (hi > lo) begin
					span = hi - lo;
					return 16'(lo + $urandom_range(0, span));
				end
				return 16'($urandom);
			end
		endcase
	endfunction

	task automatic directed_checks();
		send_cmd(spe_pkg::ACT_QUERY, 8'd0, 16'h0000, 16'h0000, 16'h0000);
		send_cmd(spe_pkg::ACT_QUERY, CAM_SERVO, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_cmd(spe_pkg::ACT_SET, CAM_SERVO, 16'h7FFF, 16'hFFFF, 16'h8000);
		send_ack(CAM_SERVO, SHAPE_GOOD);
		send_cmd(spe_pkg::ACT_SET, 8'd2, 16'h8000, 16'h0000, 16'h7FFF);
		close_window();
		send_cmd(spe_pkg::ACT_SET, 8'd0, 16'h0BB8, 16'h1234, 16'h0010);
		send_cmd(spe_pkg::ACT_SET, 8'(SERVO_COUNT + 1), 16'h0BB8, 16'h1234, 16'h0010);
		send_cmd(spe_pkg::ACT_READ, 8'd2, 16'($urandom), 16'($urandom), 16'($urandom));
		send_position_reply(8'd2, SHAPE_GOOD);
		send_cmd(spe_pkg::ACT_QUERY, 8'd2, 16'($urandom), 16'($urandom), 16'($urandom));
		// window already answered: byte ignored, end gives nothing
		send_rx(8'hFF);
		close_window();
		// a new command drops the open read window
		send_cmd(spe_pkg::ACT_READ, 8'd3, 16'($urandom), 16'($urandom), 16'($urandom));
		send_cmd(spe_pkg::ACT_SET, 8'd3, 16'h0C00, 16'h00FF, 16'hFF00);
		close_window();
		send_cmd(3'(spe_pkg::ACT_QUERY) + 3'd3, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
	endtask

	task automatic random_transaction();
		int         pick, mode;
		logic [7:0] id;
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			id = pick_servo();
			send_cmd(spe_pkg::ACT_SET, id, pick_target(id), 16'($urandom), 16'($urandom));
			if (id >= 1 && id <= SERVO_COUNT) begin
				mode = $urandom_range(0, 9);
				if (mode < 6)
					send_ack(id, SHAPE_GOOD);
				else if (mode == 6)
					send_ack(id, SHAPE_FLIP);
				else if (mode == 7)
					send_ack(id, SHAPE_SHORT);
				else if (mode == 9)
					send_ack(id, SHAPE_EXTRA);
			end
		end else if (pick < 65) begin
			id = pick_servo();
			send_cmd(spe_pkg::ACT_READ, id, 16'($urandom), 16'($urandom), 16'($urandom));
			if (id >= 1 && id <= SERVO_COUNT) begin
				mode = $urandom_range(0, 11);
				if (mode < 5)
					send_position_reply(8'($urandom_range(1, SERVO_COUNT)), SHAPE_GOOD);
				else if (mode == 5)
					send_position_reply(pick_servo(), SHAPE_HEADER);
				else if (mode == 6)
					send_position_reply(pick_servo(), SHAPE_LENGTH);
				else if (mode == 7)
					send_position_reply(pick_servo(), SHAPE_CHECKSUM);
				else if (mode == 8)
					send_position_reply(8'($urandom_range(SERVO_COUNT + 1, 256)), SHAPE_GOOD);
				else if (mode == 9)
					send_position_reply(pick_servo(), SHAPE_SHORT);
				else if (mode == 11)
					send_position_reply(8'($urandom_range(1, SERVO_COUNT)), SHAPE_EXTRA);
			end
		end else if (pick < 80) begin
			id = $urandom_range(0, 1) ? pick_servo() : 8'($urandom_range(0, SERVO_COUNT + 1));
			send_cmd(spe_pkg::ACT_QUERY, id, 16'($urandom), 16'($urandom), 16'($urandom));
		end else if (pick < 90) begin
			close_window();
		end else if (pick < 95) begin
			send_rx(8'($urandom));
		end else begin
			send_cmd(3'(spe_pkg::ACT_QUERY) + 3'($urandom_range(1, 3)), 8'($urandom),
				16'($urandom), 16'($urandom), 16'($urandom));
		end
	endtask

	task automatic random_phase(int n);
		int target;
		target = items_sent + n;
		while (items_sent < target) begin
			random_transaction();
			if (!calm && $urandom_range(0, 39) == 0)
				drain_results();
		end
		drain_results();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		calm = 0;
		items_sent = 0;
		cam_hi = spe_pkg::CAM_MAX_RST;
		cam_lo = spe_pkg::CAM_MIN_RST;
		arm_hi = spe_pkg::ARM_MAX_RST;
		arm_lo = spe_pkg::ARM_MIN_RST;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// limits as they come out of reset
		directed_checks();
		drain_results();
		random_phase(25);

		// widest range: no value clamps
		set_limits(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
		random_phase(25);

		// crossed limits, upper clamp takes priority
		set_limits(16'hFF9C, 16'h0064, 16'h8000, 16'h7FFF);
		random_phase(20);

		set_limits(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		random_phase(20);

		// closing stretch without gaps or stalls
		set_limits(16'h0000, 16'h0000, 16'h7FFF, 16'hF000);
		calm = 1;
		random_phase(20);

		if (mismatch_count == 0 && results_due == 0)
			$display("servo_packet_engine verification clean");
		else
			$display("servo_packet_engine verification failed");
		$finish;
	end

endmodule

### sim.f
src/spe_pkg.sv
src/spe_core.sv
src/spe_out.sv
src/servo_packet_engine.sv
bench/servo_frame_tracker.sv
bench/tb_servo_packet_engine.sv
